// ----- hw/rtl/p256_pkg.sv -----
// p256_pkg: types, constants and helper functions for the P-256 field ALU
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package p256_pkg;

  localparam int NS = 14;
  localparam int RW = 260;
  localparam int ZW = 16;

  localparam logic [255:0] P =
    256'hffffffff00000001000000000000000000000000ffffffffffffffffffffffff;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [63:0] a_limb0;
    logic [63:0] a_limb1;
    logic [63:0] a_limb2;
    logic [63:0] a_limb3;
    logic [63:0] b_limb0;
    logic [63:0] b_limb1;
    logic [63:0] b_limb2;
    logic [63:0] b_limb3;
  } req_t;

  typedef struct packed {
    logic [63:0] r_limb0;
    logic [63:0] r_limb1;
    logic [63:0] r_limb2;
    logic [63:0] r_limb3;
  } rsp_t;

  typedef struct packed {
    cmd_t         cmd;
    logic [256:0] as;
  } side_t;

  typedef logic [4:0] sel_t;

  // word selection for s2..s9 out of product words, zw gives zero
  localparam sel_t PICK [8][8] = '{
    '{5'd16, 5'd16, 5'd16, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15},
    '{5'd16, 5'd16, 5'd16, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16},
    '{5'd8,  5'd9,  5'd10, 5'd16, 5'd16, 5'd16, 5'd14, 5'd15},
    '{5'd9,  5'd10, 5'd11, 5'd13, 5'd14, 5'd15, 5'd13, 5'd8},
    '{5'd11, 5'd12, 5'd13, 5'd16, 5'd16, 5'd16, 5'd8,  5'd10},
    '{5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd16, 5'd9,  5'd11},
    '{5'd13, 5'd14, 5'd15, 5'd8,  5'd9,  5'd10, 5'd16, 5'd12},
    '{5'd14, 5'd15, 5'd16, 5'd9,  5'd10, 5'd11, 5'd16, 5'd13}
  };

  function automatic logic [255:0] red1(logic [255:0] x);
    logic [256:0] d;
    d = {1'b0, x} - {1'b0, P};
    return d[256] ? x : d[255:0];
  endfunction

  function automatic logic [RW-1:0] csub(logic [RW-1:0] x, logic [RW-1:0] m);
    logic [RW:0] d;
    d = {1'b0, x} - {1'b0, m};
    return d[RW] ? x : d[RW-1:0];
  endfunction

  function automatic logic [255:0] sel_words(logic [511:0] c, int k);
    logic [255:0] s;
    sel_t idx;
    s = '0;
    for (int j = 0; j < 8; j++) begin
      idx = PICK[k][j];
      if (idx != sel_t'(ZW)) begin
        s[32*j +: 32] = c[32*int'(idx[3:0]) +: 32];
      end
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/p256_front.sv -----
// p256_front: operand reduction, add/subtract value and 32x32 partial products
// two register stages; depends on p256_pkg
`timescale 1ns / 1ps
`default_nettype none
module p256_front (
  input  wire logic                clk,
  input  wire logic [1:0]          en,
  input  wire p256_pkg::req_t      req,
  output logic [63:0]              pp [8][8],
  output p256_pkg::side_t          side
);
  import p256_pkg::*;

  logic [255:0] a_r, b_r;
  cmd_t         cmd_r;
  logic [256:0] sum, diff;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_r   <= red1({req.a_limb3, req.a_limb2, req.a_limb1, req.a_limb0});
      b_r   <= red1({req.b_limb3, req.b_limb2, req.b_limb1, req.b_limb0});
      cmd_r <= req.command;
    end
  end

  always_comb begin
    sum  = {1'b0, a_r} + {1'b0, b_r};
    diff = {1'b0, a_r} + {1'b0, P} - {1'b0, b_r};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 8; i++) begin
        for (int j = 0; j < 8; j++) begin
          pp[i][j] <= a_r[32*i +: 32] * b_r[32*j +: 32];
        end
      end
      side.cmd <= cmd_r;
      side.as  <= (cmd_r == CMD_SUB) ? diff : sum;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/p256_accum.sv -----
// p256_accum: registered adder tree that sums partial products into the
// 512-bit product, four stages; depends on p256_pkg
`timescale 1ns / 1ps
`default_nettype none
module p256_accum (
  input  wire logic                clk,
  input  wire logic [3:0]          en,
  input  wire logic [63:0]         pp [8][8],
  input  wire p256_pkg::side_t     side_in,
  output logic [511:0]             c,
  output p256_pkg::side_t          side
);
  import p256_pkg::*;

  logic [511:0] rows [16];
  logic [511:0] l1 [8];
  logic [511:0] l2 [4];
  logic [511:0] l3 [2];
  side_t        s3, s4, s5;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rows[2*i]   = 512'({pp[i][6], pp[i][4], pp[i][2], pp[i][0]}) << (32*i);
      rows[2*i+1] = 512'({pp[i][7], pp[i][5], pp[i][3], pp[i][1]}) << (32*(i+1));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 8; k++) l1[k] <= rows[2*k] + rows[2*k+1];
      s3 <= side_in;
    end
    if (en[1]) begin
      for (int k = 0; k < 4; k++) l2[k] <= l1[2*k] + l1[2*k+1];
      s4 <= s3;
    end
    if (en[2]) begin
      for (int k = 0; k < 2; k++) l3[k] <= l2[2*k] + l2[2*k+1];
      s5 <= s4;
    end
    if (en[3]) begin
      c    <= l3[0] + l3[1];
      side <= s5;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/p256_reduce.sv -----
// p256_reduce: fast reduction sums, command select and multiple-of-p
// correction, eight stages ending in the output register; depends on p256_pkg
`timescale 1ns / 1ps
`default_nettype none
module p256_reduce (
  input  wire logic                clk,
  input  wire logic [7:0]          en,
  input  wire logic [511:0]        c,
  input  wire p256_pkg::side_t     side_in,
  output logic [255:0]             r
);
  import p256_pkg::*;

  localparam logic [RW-1:0] PW = RW'(P);
  localparam logic [RW-1:0] P5 = PW * 5;

  logic [RW-1:0] p1, p2, p3, n1, n2;
  logic [RW-1:0] q1, q2, n2b;
  logic [RW-1:0] u, n2c;
  logic [RW-1:0] t, t11, t12, t13;
  logic [RW-1:0] t_next;
  logic [RW-1:0] r_full;
  side_t         s7, s8, s9;

  always_comb begin
    case (s9.cmd)
      CMD_MUL:          t_next = u - n2c;
      CMD_ADD, CMD_SUB: t_next = RW'(s9.as);
      default:          t_next = '0;
    endcase
  end

  assign r_full = csub(t13, PW);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1 <= RW'(c[255:0]) + (RW'(sel_words(c, 0)) << 1);
      p2 <= (RW'(sel_words(c, 1)) << 1) + RW'(sel_words(c, 2));
      p3 <= RW'(sel_words(c, 3)) + P5;
      n1 <= RW'(sel_words(c, 4)) + RW'(sel_words(c, 5));
      n2 <= RW'(sel_words(c, 6)) + RW'(sel_words(c, 7));
      s7 <= side_in;
    end
    if (en[1]) begin
      q1  <= p1 + p2;
      q2  <= p3 - n1;
      n2b <= n2;
      s8  <= s7;
    end
    if (en[2]) begin
      u   <= q1 + q2;
      n2c <= n2b;
      s9  <= s8;
    end
    if (en[3]) t   <= t_next;
    if (en[4]) t11 <= csub(t, PW << 3);
    if (en[5]) t12 <= csub(t11, PW << 2);
    if (en[6]) t13 <= csub(t12, PW << 1);
    if (en[7]) r   <= r_full[255:0];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/p256_field_alu.sv -----
// p256_field_alu: top level of the P-256 field ALU, valid tracking and stalls
// depends on p256_pkg, p256_front, p256_accum and p256_reduce
//
// One add, subtract or multiply modulo the P-256 prime enters per clock unless
// rsp_ready stalls the pipeline, and its result leaves reduced; all commands
// pass the same stages: the operand and partial-product stages, the four-level
// adder tree over the 512-bit product and the reduction and correction stages.
// Each stage has its own valid bit and holds only while the stage after it is
// full and held, so gaps close up and a transaction is accepted while a result
// waits. Operands at or above p are reduced on entry; command 3 returns zero.
`timescale 1ns / 1ps
`default_nettype none
module p256_field_alu (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire p256_pkg::req_t    req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output p256_pkg::rsp_t         rsp
);
  import p256_pkg::*;

  logic [NS:1]   v;
  logic [NS:1]   vin;
  logic [NS:1]   en;
  logic [63:0]   pp [8][8];
  side_t         side2, side6;
  logic [511:0]  c;
  logic [255:0]  r;

  always_comb begin
    en[NS] = !v[NS] || rsp_ready;
    for (int k = NS - 1; k >= 1; k--) en[k] = !v[k] || en[k+1];
    vin = {v[NS-1:1], req_valid};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) v[k] <= vin[k];
      end
    end
  end

  p256_front u_front (
    .clk  (clk),
    .en   (en[2:1]),
    .req  (req),
    .pp   (pp),
    .side (side2)
  );

  p256_accum u_accum (
    .clk     (clk),
    .en      (en[6:3]),
    .pp      (pp),
    .side_in (side2),
    .c       (c),
    .side    (side6)
  );

  p256_reduce u_reduce (
    .clk     (clk),
    .en      (en[14:7]),
    .c       (c),
    .side_in (side6),
    .r       (r)
  );

  assign req_ready   = en[1];
  assign rsp_valid   = v[NS];
  assign rsp.r_limb0 = r[63:0];
  assign rsp.r_limb1 = r[127:64];
  assign rsp.r_limb2 = r[191:128];
  assign rsp.r_limb3 = r[255:192];

`ifndef SYNTHESIS
  a_result_below_p: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (r < P))
    else $error("result not reduced below p");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> ((&v) && !rsp_ready))
    else $error("input held while pipeline has room");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");
`endif

endmodule
`default_nettype wire
